// ----- rtl/mbe_pkg.sv -----
// Shared types and constants of the Mandelbrot escape-time unit.
// Used by mbe_core and mandelbrot_escape_time_unit; depends on nothing.
package mbe_pkg;

    // Fixed-point format of all complex-plane values (signed Q4.28)
    localparam int FRACTION_BITS = 28;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int ITER_BITS     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_ORIGIN   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_STEP     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ITER_LIMIT = 3'd4;

    // Reset values
    localparam logic signed [CFG_DATA_BITS-1:0] X_ORIGIN_RST = -32'sd590558003;
    localparam logic signed [CFG_DATA_BITS-1:0] Y_ORIGIN_RST = -32'sd456340275;
    localparam logic signed [CFG_DATA_BITS-1:0] X_STEP_RST   = 32'sd760567;
    localparam logic signed [CFG_DATA_BITS-1:0] Y_STEP_RST   = 32'sd760567;
    localparam logic [ITER_BITS-1:0]            ITER_LIMIT_RST = 16'd500;

    typedef struct packed {
        logic signed [CFG_DATA_BITS-1:0] x_origin;
        logic signed [CFG_DATA_BITS-1:0] y_origin;
        logic signed [CFG_DATA_BITS-1:0] x_step;
        logic signed [CFG_DATA_BITS-1:0] y_step;
        logic [ITER_BITS-1:0]            iter_limit;
    } t_cfg;

endpackage

// ----- rtl/mbe_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
// Generic; DEPTH must be a power of two. No package dependency.
module mbe_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/mbe_core.sv -----
// Iteration engine: maps a pixel to c and runs z = z*z + c until escape or limit.
// Depends on mbe_pkg (t_cfg, FRACTION_BITS, CFG_DATA_BITS, ITER_BITS).
module mbe_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbe_pkg::t_cfg                  i_cfg,
    input  logic                           i_pix_empty,
    input  logic [2*COORD_BITS-1:0]        i_pix_data,
    output logic                           o_pix_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output logic [mbe_pkg::ITER_BITS-1:0]  o_res_data
);
    localparam int F   = mbe_pkg::FRACTION_BITS;
    localparam int DW  = mbe_pkg::CFG_DATA_BITS;
    localparam int PW  = COORD_BITS + DW + 1;             // coordinate * step
    localparam int CW  = PW + 1;                          // c = origin + product
    localparam int ZW  = ((CW > F + 4) ? CW : F + 4) + 1; // z after one update
    localparam int SW  = F + 2;                           // truncated square
    localparam logic [ZW-1:0]  TWO  = ZW'(1) << (F + 1);
    localparam logic [SW:0]    FOUR = (SW + 1)'(1) << (F + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [COORD_BITS-1:0]         r_px;
    logic [COORD_BITS-1:0]         r_py;
    logic signed [CW-1:0]          r_cr;
    logic signed [CW-1:0]          r_ci;
    logic [ZW-1:0]                 r_mr;
    logic [ZW-1:0]                 r_mi;
    logic                          r_zr_neg;
    logic                          r_zi_neg;
    logic [SW-1:0]                 r_sr;
    logic [SW-1:0]                 r_si;
    logic [SW-1:0]                 r_pm;
    logic                          r_pneg;
    logic [mbe_pkg::ITER_BITS-1:0] r_count;

    logic signed [PW-1:0]          w_xprod;
    logic signed [PW-1:0]          w_yprod;
    logic signed [CW-1:0]          w_cr;
    logic signed [CW-1:0]          w_ci;
    logic                          w_esc;
    logic [2*F+1:0]                w_sq_r;
    logic [2*F+1:0]                w_sq_i;
    logic [2*F+1:0]                w_prod;
    logic [SW:0]                   w_sum;
    logic signed [ZW-1:0]          w_p2;
    logic signed [ZW-1:0]          w_nzr;
    logic signed [ZW-1:0]          w_nzi;

    // Coordinate mapping
    always_comb begin
        w_xprod = $signed({1'b0, r_px}) * i_cfg.x_step;
        w_yprod = $signed({1'b0, r_py}) * i_cfg.y_step;
        w_cr    = CW'(w_xprod) + CW'(i_cfg.x_origin);
        w_ci    = CW'(w_yprod) + CW'(i_cfg.y_origin);
    end

    // Multiply phase: both magnitudes are below two here, so F+1 bits suffice
    always_comb begin
        w_esc  = (r_count >= i_cfg.iter_limit) || (r_mr >= TWO) || (r_mi >= TWO);
        w_sq_r = r_mr[F:0] * r_mr[F:0];
        w_sq_i = r_mi[F:0] * r_mi[F:0];
        w_prod = r_mr[F:0] * r_mi[F:0];
    end

    // Add phase
    always_comb begin
        w_sum = {1'b0, r_sr} + {1'b0, r_si};
        w_p2  = $signed(ZW'({r_pm, 1'b0}));
        w_nzr = $signed(ZW'(r_sr)) - $signed(ZW'(r_si)) + ZW'(r_cr);
        w_nzi = (r_pneg ? -w_p2 : w_p2) + ZW'(r_ci);
    end

    assign o_pix_pop  = (r_state == S_IDLE) && !i_pix_empty;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;
    assign o_res_data = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_pix_empty) begin
                        r_px    <= i_pix_data[2*COORD_BITS-1:COORD_BITS];
                        r_py    <= i_pix_data[COORD_BITS-1:0];
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_cr     <= w_cr;
                    r_ci     <= w_ci;
                    r_mr     <= '0;
                    r_mi     <= '0;
                    r_zr_neg <= 1'b0;
                    r_zi_neg <= 1'b0;
                    r_count  <= '0;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (w_esc) begin
                        r_state <= S_DONE;
                    end else begin
                        // drop the fraction bits of each exact product
                        r_sr    <= w_sq_r[2*F+1:F];
                        r_si    <= w_sq_i[2*F+1:F];
                        r_pm    <= w_prod[2*F+1:F];
                        r_pneg  <= r_zr_neg ^ r_zi_neg;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (w_sum >= FOUR) begin
                        r_state <= S_DONE;
                    end else begin
                        r_zr_neg <= w_nzr[ZW-1];
                        r_zi_neg <= w_nzi[ZW-1];
                        r_mr     <= w_nzr[ZW-1] ? ZW'(-w_nzr) : ZW'(w_nzr);
                        r_mi     <= w_nzi[ZW-1] ? ZW'(-w_nzi) : ZW'(w_nzi);
                        r_count  <= r_count + 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/mandelbrot_escape_time_unit.sv -----
// Mandelbrot escape-time unit: pixel queue, iteration engine, result queue.
// The engine works on one pixel at a time, with a multiply step and an add step per
// iteration, and takes the next pixel only once the result has been pushed.
// Reset (synchronous, active low) empties both queues, idles the engine and
// loads the default view (origin, step, iteration limit of 500).
module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [COORD_BITS-1:0]               i_pixel_x,
    input  logic [COORD_BITS-1:0]               i_pixel_y,
    output logic                                empty,
    input  logic                                pop,
    output logic [mbe_pkg::ITER_BITS-1:0]       o_iteration_count,
    input  logic                                i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    localparam int RES_DEPTH = 2;

    mbe_pkg::t_cfg                 r_cfg;
    logic                          w_pix_empty;
    logic [2*COORD_BITS-1:0]       w_pix_data;
    logic                          w_pix_pop;
    logic                          w_res_full;
    logic                          w_res_push;
    logic [mbe_pkg::ITER_BITS-1:0] w_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin   <= mbe_pkg::X_ORIGIN_RST;
            r_cfg.y_origin   <= mbe_pkg::Y_ORIGIN_RST;
            r_cfg.x_step     <= mbe_pkg::X_STEP_RST;
            r_cfg.y_step     <= mbe_pkg::Y_STEP_RST;
            r_cfg.iter_limit <= mbe_pkg::ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbe_pkg::CFG_X_ORIGIN:   r_cfg.x_origin   <= $signed(i_cfg_wdata);
                mbe_pkg::CFG_Y_ORIGIN:   r_cfg.y_origin   <= $signed(i_cfg_wdata);
                mbe_pkg::CFG_X_STEP:     r_cfg.x_step     <= $signed(i_cfg_wdata);
                mbe_pkg::CFG_Y_STEP:     r_cfg.y_step     <= $signed(i_cfg_wdata);
                mbe_pkg::CFG_ITER_LIMIT:
                    r_cfg.iter_limit <= i_cfg_wdata[mbe_pkg::ITER_BITS-1:0];
                default: ; // unknown index: drop the write
            endcase
        end
    end

    mbe_fifo #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_pix_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({i_pixel_x, i_pixel_y}),
        .o_full  (full),
        .i_pop   (w_pix_pop),
        .o_empty (w_pix_empty),
        .o_data  (w_pix_data)
    );

    mbe_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_empty (w_pix_empty),
        .i_pix_data  (w_pix_data),
        .o_pix_pop   (w_pix_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_data)
    );

    mbe_fifo #(
        .WIDTH (mbe_pkg::ITER_BITS),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_iteration_count)
    );

endmodule
